// ===== rtl/core/fir_pkg.sv =====
// fir_pkg: shared constants, types and the digit-to-character function for
// the radix formatter. No dependencies; every other file of the block uses it.

package fir_pkg;

    // sizes
    localparam int MAX_DIGITS  = 64;
    localparam int VALUE_W     = 64;
    localparam int MAG_BITS    = VALUE_W - 1;
    localparam int BASE_W      = 6;
    localparam int DIGIT_W     = 6;
    localparam int CHAR_W      = 7;

    // bit stream through the chain: last bit reaches the top cell here
    localparam int CONV_CYCLES = MAG_BITS + MAX_DIGITS - 1;
    localparam int CNT_W       = $clog2(CONV_CYCLES);

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [MAG_BITS-1:0] t_mag;

    // ascii codes
    localparam t_char CHAR_ZERO  = 7'h30;
    localparam t_char CHAR_A_LOW = 7'h61;
    localparam t_char CHAR_L_UP  = 7'h4C;
    localparam t_char CHAR_MINUS = 7'h2D;

    // base limits and special digit values
    localparam t_digit BASE_MIN  = 6'd2;
    localparam t_digit BASE_MAX  = 6'd36;
    localparam t_digit DIGIT_TEN = 6'd10;
    localparam t_digit DIGIT_L   = 6'd21;

    // what one cell hands to the cell above it
    typedef struct packed {
        logic   valid;
        logic   carry;
        t_digit digit;
    } t_link;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic   clear;
        logic   shift;
        t_digit base;
    } t_cell_ctrl;

    // digit value to its character, upper-case for twenty-one
    function automatic t_char digit_char(input t_digit d);
        t_char c;
        if (d < DIGIT_TEN) begin
            c = CHAR_ZERO + t_char'(d);
        end else if (d == DIGIT_L) begin
            c = CHAR_L_UP;
        end else begin
            c = CHAR_A_LOW + t_char'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/fir_if.sv =====
// fir_if: valid/ready channel interfaces of the radix formatter, one for the
// input word and one for the character word. Depends on fir_pkg.

interface fir_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [fir_pkg::VALUE_W-1:0] value;
    logic        [fir_pkg::BASE_W-1:0]  base;

    modport source (output valid, output value, output base, input ready);
    modport sink   (input valid, input value, input base, output ready);
endinterface

interface fir_out_if;
    logic                        valid;
    logic                        ready;
    logic [fir_pkg::CHAR_W-1:0]  character;
    logic                        last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== rtl/core/format_integer_radix.sv =====
// format_integer_radix: top level of the radix formatter, with the sequencer
// and the character output. Depends on fir_pkg, fir_if and fir_chain.
//
// Usage:
//  i_in carries one signed 64-bit value and a base; a base below 2 counts
//  as 2 and one above 36 as 36. o_out returns the text of the value as one
//  ascii character per word, most significant digit first, with '-' ahead
//  of a negative value and last set on the final character.
//  A word is taken on i_in only while the block is idle (ready high).
//  After acceptance the magnitude is streamed bit-serially through the
//  chain of 64 digit cells, a conversion set by the 63 magnitude bits
//  plus the 63-cell skew up the chain. The sign, if any, follows, held
//  until the receiver takes it. The chain is then unloaded from the top in
//  64 steps: leading zeros are dropped at one a cycle, and characters go
//  out at one a cycle while the receiver is ready.
//  A stalled receiver holds the current character and freezes the chain.
//  Reset (synchronous, active low) returns the block to idle and drops
//  any number in progress.

module format_integer_radix (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fir_in_if.sink       i_in,
    fir_out_if.source    o_out
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SIGN = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    fir_pkg::t_cnt        r_cnt, n_cnt;
    fir_pkg::t_mag        r_mag, n_mag;
    logic                 r_neg, n_neg;
    fir_pkg::t_digit      r_base, n_base;
    logic                 r_seen, n_seen;

    logic                 in_acc;
    logic                 out_acc;
    logic [fir_pkg::VALUE_W-1:0] neg_val;
    fir_pkg::t_mag        in_mag;
    fir_pkg::t_digit      in_base;
    fir_pkg::t_digit      top_digit;
    logic                 top_nz;
    logic                 final_dig;
    logic                 show;
    fir_pkg::t_cell_ctrl  ctrl;
    fir_pkg::t_link       feed;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    // magnitude of the input, most negative value clamped
    always_comb begin
        neg_val = {fir_pkg::VALUE_W{1'b0}} - i_in.value;
        if (!i_in.value[fir_pkg::VALUE_W-1]) begin
            in_mag = i_in.value[fir_pkg::MAG_BITS-1:0];
        end else if (neg_val[fir_pkg::VALUE_W-1]) begin
            in_mag = '1;
        end else begin
            in_mag = neg_val[fir_pkg::MAG_BITS-1:0];
        end
    end

    // base saturated into range
    always_comb begin
        if (i_in.base < fir_pkg::BASE_MIN) begin
            in_base = fir_pkg::BASE_MIN;
        end else if (i_in.base > fir_pkg::BASE_MAX) begin
            in_base = fir_pkg::BASE_MAX;
        end else begin
            in_base = i_in.base;
        end
    end

    // unload view of the top cell
    assign top_nz    = top_digit != '0;
    assign final_dig = r_cnt == fir_pkg::t_cnt'(1);
    assign show      = r_seen || top_nz || final_dig;

    // chain control and bit feed
    always_comb begin
        ctrl.clear = in_acc;
        ctrl.shift = (r_state == ST_EMIT) && (!show || o_out.ready);
        ctrl.base  = r_base;
        feed.valid = (r_state == ST_CONV) && (r_cnt < fir_pkg::t_cnt'(fir_pkg::MAG_BITS));
        feed.carry = r_mag[fir_pkg::MAG_BITS-1];
        feed.digit = '0;
    end

    fir_chain u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_feed      (feed),
        .o_top_digit (top_digit)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_base  = r_base;
        n_seen  = r_seen;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_CONV;
                    n_cnt   = '0;
                    n_mag   = in_mag;
                    n_neg   = i_in.value[fir_pkg::VALUE_W-1];
                    n_base  = in_base;
                    n_seen  = 1'b0;
                end
            end
            ST_CONV: begin
                n_mag = {r_mag[fir_pkg::MAG_BITS-2:0], 1'b0};
                if (r_cnt == fir_pkg::t_cnt'(fir_pkg::CONV_CYCLES - 1)) begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                    n_cnt   = fir_pkg::t_cnt'(fir_pkg::MAX_DIGITS);
                end else begin
                    n_cnt = r_cnt + fir_pkg::t_cnt'(1);
                end
            end
            ST_SIGN: begin
                if (out_acc) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (ctrl.shift) begin
                    n_cnt  = r_cnt - fir_pkg::t_cnt'(1);
                    n_seen = r_seen || top_nz;
                    if (final_dig) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_seen  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_seen  <= n_seen;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_base <= n_base;
    end

    // channel outputs
    assign i_in.ready      = r_state == ST_IDLE;
    assign o_out.valid     = (r_state == ST_SIGN) || ((r_state == ST_EMIT) && show);
    assign o_out.character = (r_state == ST_SIGN) ? fir_pkg::CHAR_MINUS
                                                  : fir_pkg::digit_char(top_digit);
    assign o_out.last      = (r_state == ST_EMIT) && final_dig;

    // an accepted word always starts a fresh conversion from count zero
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_CONV) && (r_cnt == '0))
        else $error("conversion did not start after input accept");

    // the final character hands control back to idle
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out.last) |=> (r_state == ST_IDLE))
        else $error("block not idle after final character");

    // unload count never runs dry while digits remain
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_cnt != '0))
        else $error("unload count reached zero in emit");

    // a sign is only sent for a negative value
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIGN) |-> r_neg)
        else $error("sign emitted for non-negative value");

    // the chain never shifts while a character is held for the receiver
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !ctrl.shift)
        else $error("chain shifted under a stalled character");

endmodule

// ===== rtl/core/fir_cell.sv =====
// fir_cell: one digit cell of the conversion chain. Doubles its digit and adds
// the carry from below, modulo the base; shifts digits up when unloading.
// Depends on fir_pkg.

module fir_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fir_pkg::t_cell_ctrl i_ctrl,
    input  fir_pkg::t_link      i_link,
    output fir_pkg::t_link      o_link
);

    logic                    r_valid;
    logic                    r_carry;
    fir_pkg::t_digit         r_digit;
    logic [fir_pkg::DIGIT_W:0] n_sum;
    logic                    n_carry;
    fir_pkg::t_digit         n_digit;

    // 2*digit + carry, then one compare and subtract
    always_comb begin
        n_sum   = {r_digit, i_link.carry};
        n_carry = n_sum >= {1'b0, i_ctrl.base};
        if (n_carry) begin
            n_digit = fir_pkg::t_digit'(n_sum - {1'b0, i_ctrl.base});
        end else begin
            n_digit = n_sum[fir_pkg::DIGIT_W-1:0];
        end
    end

    // digit register and token handed upward
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_valid <= 1'b0;
            r_carry <= 1'b0;
            r_digit <= '0;
        end else if (i_ctrl.shift) begin
            r_valid <= 1'b0;
            r_carry <= 1'b0;
            r_digit <= i_link.digit;
        end else begin
            r_valid <= i_link.valid;
            if (i_link.valid) begin
                r_carry <= n_carry;
                r_digit <= n_digit;
            end
        end
    end

    assign o_link = '{valid: r_valid, carry: r_carry, digit: r_digit};

endmodule

// ===== rtl/core/fir_chain.sv =====
// fir_chain: row of digit cells, least significant at the bottom. The
// magnitude enters bit by bit at the bottom; the top digit leaves first.
// Depends on fir_pkg and fir_cell.

module fir_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fir_pkg::t_cell_ctrl i_ctrl,
    input  fir_pkg::t_link      i_feed,
    output fir_pkg::t_digit     o_top_digit
);

    fir_pkg::t_link links [fir_pkg::MAX_DIGITS+1];

    assign links[0] = i_feed;

    // one cell per digit position
    for (genvar g = 0; g < fir_pkg::MAX_DIGITS; g++) begin : g_cell
        fir_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (i_ctrl),
            .i_link  (links[g]),
            .o_link  (links[g+1])
        );
    end

    assign o_top_digit = links[fir_pkg::MAX_DIGITS].digit;

endmodule

// ===== test/testbench.sv =====
// testbench: self-checking bench for format_integer_radix, driving numbers and bases
// in and checking every character word against typed text or a local text predictor.
// Depends on fir_pkg, fir_if and the format_integer_radix rtl.
`timescale 1ns / 1ps

module testbench;

    localparam logic signed [fir_pkg::VALUE_W-1:0] VAL_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [fir_pkg::VALUE_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;
    localparam longint TIMEOUT_NS = 64'd20_000_000;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        fir_pkg::t_char character;
        logic           last;
    } t_char_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fir_in_if  word_in ();
    fir_out_if char_out ();

    format_integer_radix uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (word_in),
        .o_out   (char_out)
    );

    // characters still owed by the block, oldest first
    t_char_word expected_chars[$];

    // directed stimulus table
    logic signed [fir_pkg::VALUE_W-1:0] dir_value[$];
    logic [fir_pkg::BASE_W-1:0]         dir_base[$];
    string                              dir_text[$];

    string digit_glyphs = "0123456789abcdefghijkLmnopqrstuvwxyz";

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int numbers_sent   = 0;
    int chars_seen     = 0;

    // 20 ns clock
    always #10 i_clk = ~i_clk;

    // text of a number: saturate the base, clamp the magnitude, digits msb first
    function automatic void predict_text(input logic signed [fir_pkg::VALUE_W-1:0] v,
                                         input logic [fir_pkg::BASE_W-1:0] b);
        logic [fir_pkg::VALUE_W-1:0] mag;
        logic [fir_pkg::VALUE_W-1:0] radix;
        fir_pkg::t_digit             digit_buf [fir_pkg::MAX_DIGITS];
        int                          n;
        t_char_word                  w;
        radix = (b < fir_pkg::BASE_MIN) ? fir_pkg::VALUE_W'(fir_pkg::BASE_MIN) :
                (b > fir_pkg::BASE_MAX) ? fir_pkg::VALUE_W'(fir_pkg::BASE_MAX) :
                                          fir_pkg::VALUE_W'(b);
        mag = v[fir_pkg::VALUE_W-1] ? (64'd0 - v) : v;
        if (mag > 64'h7fff_ffff_ffff_ffff) mag = 64'h7fff_ffff_ffff_ffff;
        if (mag == 0) begin
            w.character = fir_pkg::CHAR_ZERO;
            w.last      = 1'b1;
            expected_chars.push_back(w);
            return;
        end
        n = 0;
        while (mag != 0 && n < fir_pkg::MAX_DIGITS) begin
            digit_buf[n] = fir_pkg::t_digit'(mag % radix);
            mag          = mag / radix;
            n++;
        end
        if (v[fir_pkg::VALUE_W-1]) begin
            w.character = fir_pkg::CHAR_MINUS;
            w.last      = 1'b0;
            expected_chars.push_back(w);
        end
        for (int i = n - 1; i >= 0; i--) begin
            w.character = fir_pkg::t_char'(digit_glyphs[digit_buf[i]]);
            w.last      = (i == 0);
            expected_chars.push_back(w);
        end
    endfunction

    function automatic void add_case(input logic signed [fir_pkg::VALUE_W-1:0] v,
                                     input logic [fir_pkg::BASE_W-1:0] b,
                                     input string text);
        dir_value.push_back(v);
        dir_base.push_back(b);
        dir_text.push_back(text);
    endfunction

    // offer one number word; on acceptance queue its text (typed or predicted)
    task automatic send_word(input logic signed [fir_pkg::VALUE_W-1:0] v,
                             input logic [fir_pkg::BASE_W-1:0] b, input string text);
        t_char_word w;
        while ($urandom_range(99) < send_idle_pct) begin
            word_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        word_in.valid <= 1'b1;
        word_in.value <= v;
        word_in.base  <= b;
        do @(posedge i_clk); while (!word_in.ready);
        numbers_sent++;
        if (text.len() == 0) begin
            predict_text(v, b);
        end else begin
            for (int k = 0; k < text.len(); k++) begin
                w.character = fir_pkg::t_char'(text[k]);
                w.last      = (k == text.len() - 1);
                expected_chars.push_back(w);
            end
        end
    endtask

    // random numbers under one idle and stall setting
    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        logic signed [fir_pkg::VALUE_W-1:0] v;
        logic [fir_pkg::VALUE_W-1:0]        p;
        logic [fir_pkg::BASE_W-1:0]         b;
        int                                 kind;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            // mostly legal bases, some from the whole field to hit saturation
            b = ($urandom_range(3) == 0) ?
                fir_pkg::BASE_W'($urandom_range(63)) :
                fir_pkg::BASE_W'($urandom_range(fir_pkg::BASE_MIN, fir_pkg::BASE_MAX));
            kind = $urandom_range(4);
            case (kind)
                0: v = {$urandom, $urandom};
                1: v = fir_pkg::VALUE_W'($urandom_range(1000));
                2: v = {$urandom, $urandom} >> $urandom_range(63);
                3: begin
                    // near a power of the base, where the digit count changes
                    b = fir_pkg::BASE_W'($urandom_range(fir_pkg::BASE_MIN, fir_pkg::BASE_MAX));
                    p = 1;
                    repeat ($urandom_range(1, 63)) begin
                        if (p <= VAL_MAX / b) p = p * b;
                    end
                    v = p - fir_pkg::VALUE_W'($urandom_range(1));
                end
                default: begin
                    case ($urandom_range(3))
                        0:       v = VAL_MAX;
                        1:       v = VAL_MIN;
                        2:       v = 0;
                        default: v = 1;
                    endcase
                end
            endcase
            if (kind != 0 && $urandom_range(1)) v = -v;
            send_word(v, b, "");
        end
    endtask

    // character sink: random stalls, compare each word with the oldest expectation
    always @(posedge i_clk) begin : char_check
        t_char_word want;
        if (i_rst_n && char_out.valid && char_out.ready) begin
            chars_seen++;
            if (expected_chars.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected word: char '%c' (0x%h) last %0d",
                             char_out.character, char_out.character, char_out.last);
            end else begin
                want = expected_chars.pop_front();
                if (char_out.character !== want.character || char_out.last !== want.last) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display({"mismatch: expected '%c' (0x%h) last %0d,",
                                  " got '%c' (0x%h) last %0d"},
                                 want.character, want.character, want.last,
                                 char_out.character, char_out.character, char_out.last);
                end
            end
        end
        char_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // stimulus and end of run
    initial begin : stimulus
        word_in.valid  = 1'b0;
        word_in.value  = '0;
        word_in.base   = fir_pkg::BASE_MIN;
        char_out.ready = 1'b0;
        i_rst_n        = 1'b0;

        // value, base, expected text (empty: predicted)
        add_case(0,        6'd10, "0");
        add_case(0,        6'd63, "0");
        add_case(1,        6'd2,  "1");
        add_case(-1,       6'd2,  "-1");
        add_case(9,        6'd10, "9");
        add_case(10,       6'd36, "a");
        add_case(20,       6'd36, "k");
        add_case(21,       6'd36, "L");
        add_case(22,       6'd36, "m");
        add_case(35,       6'd36, "z");
        add_case(777,      6'd36, "LL");
        add_case(5,        6'd0,  "101");
        add_case(5,        6'd1,  "101");
        add_case(35,       6'd37, "z");
        add_case(71,       6'd63, "1z");
        add_case(-255,     6'd16, "-ff");
        add_case(VAL_MAX,  6'd16, "7fffffffffffffff");
        add_case(-VAL_MAX, 6'd16, "-7fffffffffffffff");
        add_case(VAL_MIN,  6'd16, "-7fffffffffffffff");
        add_case(VAL_MAX,  6'd10, "9223372036854775807");
        add_case(VAL_MIN,  6'd10, "-9223372036854775807");
        add_case(VAL_MAX,  6'd2,  "");
        add_case(VAL_MIN,  6'd2,  "");
        add_case(VAL_MAX,  6'd36, "");
        add_case(-VAL_MAX, 6'd7,  "");

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_value[i]) send_word(dir_value[i], dir_base[i], dir_text[i]);

        run_phase(0,  0,  59);
        run_phase(66, 0,  59);
        run_phase(0,  66, 59);
        run_phase(27, 27, 59);
        word_in.valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d numbers converted (directed and random, bases 0..63, sign and clamp)",
                 numbers_sent);
        $display("%0d characters checked under idle and stall mixes, %0d errors",
                 chars_seen, error_count);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timeout: %0d characters still outstanding", expected_chars.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
